FILE: rtl/hct_pkg.sv
// Package for the hours-minutes-seconds countdown timer: codes, shared types and divide-by-60.
`default_nettype none

package hct_pkg;

    // Command codes carried in the cmd field.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_TOGGLE = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 14;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMER_VALID      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMER_MODE       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION_HOURS   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION_MINUTES = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DURATION_SECONDS = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOUR       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MINUTE     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_SECOND     = 4'd7;

    localparam logic        MODE_DURATION = 1'b0;
    localparam logic        MODE_ALARM    = 1'b1;

    localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [14:0] HOUR_MAX      = 15'd16383;
    localparam logic [5:0]  MAX_SIXTY     = 6'd59;
    // Reciprocal of 15 scaled by 2**19, rounded up; exact for 15-bit dividends.
    localparam logic [15:0] RECIP_15      = 16'd34953;

    typedef struct packed {
        logic [11:0] q;
        logic [5:0]  r;
    } div60_t;

    // Settled configuration seen by the datapath.
    typedef struct packed {
        logic        timer_valid;
        logic        timer_mode;
        logic [13:0] dur_hours;
        logic [12:0] dur_min_total;
        logic [5:0]  dur_sec;
        logic [16:0] alarm_target;
    } hct_cfg_t;

    // Word handed from the load stage to the state update stage.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] hours;
        logic [12:0] min_total;
        logic [5:0]  sec;
    } hct_load_t;

    // Quotient and remainder by 60 for a 17-bit value: divide by 4 with a shift,
    // then by 15 through the scaled reciprocal.
    function automatic div60_t div60(input logic [16:0] x);
        logic [30:0] prod;
        logic [11:0] q;
        logic [17:0] back;
        logic [17:0] rem;
        div60_t      res;
        prod  = x[16:2] * RECIP_15;
        q     = prod[30:19];
        back  = {q, 6'b0} - {4'b0, q, 2'b0};
        rem   = {1'b0, x} - back;
        res.q = q;
        res.r = rem[5:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hct_if.sv
// Channel interfaces of the countdown timer: command, result and configuration write.
`default_nettype none

interface hct_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [16:0] now_seconds;
    modport source (output valid, output cmd, output now_seconds, input ready);
    modport sink (input valid, input cmd, input now_seconds, output ready);
endinterface

interface hct_res_if;
    logic        valid;
    logic        ready;
    logic [13:0] remain_hours;
    logic [5:0]  remain_minutes;
    logic [5:0]  remain_secs;
    logic        started_flag;
    logic        running_flag;
    logic        finished_flag;
    modport source (output valid, output remain_hours, output remain_minutes,
                    output remain_secs, output started_flag, output running_flag,
                    output finished_flag, input ready);
    modport sink (input valid, input remain_hours, input remain_minutes,
                  input remain_secs, input started_flag, input running_flag,
                  input finished_flag, output ready);
endinterface

interface hct_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hct_pkg::CFG_INDEX_W-1:0]    index;
    logic [hct_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hct_cfg.sv
// Configuration registers and the registered precompute of duration and alarm target.
`default_nettype none

module hct_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hct_cfg_if.sink            cfg_ch,
    output hct_pkg::hct_cfg_t  cfg
);

    logic        timer_valid_reg;
    logic        timer_mode_reg;
    logic [13:0] dur_hours_reg;
    logic [11:0] dur_minutes_reg;
    logic [11:0] dur_seconds_reg;
    logic [4:0]  alarm_hour_reg;
    logic [5:0]  alarm_minute_reg;
    logic [5:0]  alarm_second_reg;

    logic [12:0] dur_min_total_reg;
    logic [12:0] dur_min_total_next;
    logic [5:0]  dur_sec_reg;
    logic [16:0] alarm_target_reg;
    logic [16:0] alarm_target_next;
    hct_pkg::div60_t sec_split;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_valid_reg  <= 1'b0;
            timer_mode_reg   <= 1'b0;
            dur_hours_reg    <= '0;
            dur_minutes_reg  <= '0;
            dur_seconds_reg  <= '0;
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
            alarm_second_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                hct_pkg::REG_TIMER_VALID:      timer_valid_reg  <= cfg_ch.data[0];
                hct_pkg::REG_TIMER_MODE:       timer_mode_reg   <= cfg_ch.data[0];
                hct_pkg::REG_DURATION_HOURS:   dur_hours_reg    <= cfg_ch.data[13:0];
                hct_pkg::REG_DURATION_MINUTES: dur_minutes_reg  <= cfg_ch.data[11:0];
                hct_pkg::REG_DURATION_SECONDS: dur_seconds_reg  <= cfg_ch.data[11:0];
                hct_pkg::REG_ALARM_HOUR:       alarm_hour_reg   <= cfg_ch.data[4:0];
                hct_pkg::REG_ALARM_MINUTE:     alarm_minute_reg <= cfg_ch.data[5:0];
                hct_pkg::REG_ALARM_SECOND:     alarm_second_reg <= cfg_ch.data[5:0];
                default: ;
            endcase
        end
    end

    // First carry of the duration: seconds into minutes; also the alarm time in seconds of the day.
    always_comb
    begin
        sec_split          = hct_pkg::div60({5'b0, dur_seconds_reg});
        dur_min_total_next = {1'b0, dur_minutes_reg} + {1'b0, sec_split.q};
        alarm_target_next  = ({12'b0, alarm_hour_reg} << 11) + ({12'b0, alarm_hour_reg} << 10)
                           + ({12'b0, alarm_hour_reg} << 9) + ({12'b0, alarm_hour_reg} << 4)
                           + ({11'b0, alarm_minute_reg} << 6) - ({11'b0, alarm_minute_reg} << 2)
                           + {11'b0, alarm_second_reg};
    end

    always_ff @(posedge clk)
    begin
        dur_min_total_reg <= dur_min_total_next;
        dur_sec_reg       <= sec_split.r;
        alarm_target_reg  <= alarm_target_next;
    end

    assign cfg.timer_valid   = timer_valid_reg;
    assign cfg.timer_mode    = timer_mode_reg;
    assign cfg.dur_hours     = dur_hours_reg;
    assign cfg.dur_min_total = dur_min_total_reg;
    assign cfg.dur_sec       = dur_sec_reg;
    assign cfg.alarm_target  = alarm_target_reg;

endmodule

`default_nettype wire

FILE: rtl/hct_load.sv
// Input register and load stage: works out the reload time carried with every command.
`default_nettype none

module hct_load (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hct_cmd_if.sink            cmd_ch,
    input  wire hct_pkg::hct_cfg_t cfg,
    output logic               ld_valid,
    input  wire logic          ld_ready,
    output hct_pkg::hct_load_t ld
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_cmd_reg;
    logic [16:0] s1_now_reg;
    logic        ld_valid_reg;
    logic        ld_valid_next;
    hct_pkg::hct_load_t ld_reg;
    hct_pkg::hct_load_t ld_next;

    logic        s2_ready;
    logic        s1_adv;
    logic [17:0] diff;
    logic [17:0] wrapped;
    logic [16:0] alarm_secs;
    hct_pkg::div60_t alarm_split;

    assign s2_ready     = !ld_valid_reg || ld_ready;
    assign s1_adv       = s1_valid_reg && s2_ready;
    assign cmd_ch.ready = !s1_valid_reg || s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        ld_valid_next = ld_valid_reg;
        if (s1_adv)
        begin
            ld_valid_next = 1'b1;
        end
        else if (ld_ready)
        begin
            ld_valid_next = 1'b0;
        end
    end

    // Alarm: target minus now, wrapped forward one day, clamped at zero; duration mode loads the configured duration.
    always_comb
    begin
        diff    = {1'b0, cfg.alarm_target} - {1'b0, s1_now_reg};
        wrapped = diff[17] ? diff + hct_pkg::SECS_PER_DAY : diff;
        alarm_secs  = wrapped[17] ? 17'd0 : wrapped[16:0];
        alarm_split = hct_pkg::div60(alarm_secs);
        ld_next.cmd = s1_cmd_reg;
        if (cfg.timer_mode == hct_pkg::MODE_ALARM)
        begin
            ld_next.hours     = '0;
            ld_next.min_total = {1'b0, alarm_split.q};
            ld_next.sec       = alarm_split.r;
        end
        else
        begin
            ld_next.hours     = cfg.dur_hours;
            ld_next.min_total = cfg.dur_min_total;
            ld_next.sec       = cfg.dur_sec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ld_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            ld_valid_reg <= ld_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            s1_cmd_reg <= cmd_ch.cmd;
            s1_now_reg <= cmd_ch.now_seconds;
        end
        if (s1_adv)
        begin
            ld_reg <= ld_next;
        end
    end

    assign ld_valid = ld_valid_reg;
    assign ld       = ld_reg;

endmodule

`default_nettype wire

FILE: rtl/hct_core.sv
// Timer state update and result register: ticks, start, toggle and reset.
`default_nettype none

module hct_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ld_valid,
    output logic               ld_ready,
    input  wire hct_pkg::hct_load_t ld,
    input  wire hct_pkg::hct_cfg_t  cfg,
    hct_res_if.source          res_ch
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [13:0] hours_reg;
    logic [13:0] hours_next;
    logic [5:0]  minutes_reg;
    logic [5:0]  minutes_next;
    logic [5:0]  seconds_reg;
    logic [5:0]  seconds_next;
    logic        started_reg;
    logic        started_next;
    logic        running_reg;
    logic        running_next;
    logic        finished_reg;
    logic        finished_next;

    logic        adv;
    logic        at_zero;
    logic [14:0] hour_sum;
    logic [13:0] load_h;
    logic [5:0]  load_m;
    logic [5:0]  load_s;
    hct_pkg::div60_t min_split;

    assign ld_ready = !out_valid_reg || res_ch.ready;
    assign adv      = ld_valid && ld_ready;
    assign at_zero  = (hours_reg == '0) && (minutes_reg == '0) && (seconds_reg == '0);

    // Second carry of the reload time: minutes into hours, then saturation.
    always_comb
    begin
        min_split = hct_pkg::div60({4'b0, ld.min_total});
        hour_sum  = {1'b0, ld.hours} + {3'b0, min_split.q};
        if (hour_sum > hct_pkg::HOUR_MAX)
        begin
            load_h = hct_pkg::HOUR_MAX[13:0];
            load_m = hct_pkg::MAX_SIXTY;
            load_s = hct_pkg::MAX_SIXTY;
        end
        else
        begin
            load_h = hour_sum[13:0];
            load_m = min_split.r;
            load_s = ld.sec;
        end
    end

    always_comb
    begin
        hours_next    = hours_reg;
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        started_next  = started_reg;
        running_next  = running_reg;
        finished_next = finished_reg;
        if (adv && cfg.timer_valid)
        begin
            case (ld.cmd)
                hct_pkg::CMD_TICK:
                begin
                    if (at_zero)
                    begin
                        finished_next = finished_reg || running_reg;
                        running_next  = 1'b0;
                    end
                    else if (running_reg)
                    begin
                        if (seconds_reg != '0)
                        begin
                            seconds_next = seconds_reg - 6'd1;
                        end
                        else if (minutes_reg != '0)
                        begin
                            minutes_next = minutes_reg - 6'd1;
                            seconds_next = hct_pkg::MAX_SIXTY;
                        end
                        else
                        begin
                            hours_next   = hours_reg - 14'd1;
                            minutes_next = hct_pkg::MAX_SIXTY;
                            seconds_next = hct_pkg::MAX_SIXTY;
                        end
                    end
                end
                hct_pkg::CMD_START:
                begin
                    hours_next    = load_h;
                    minutes_next  = load_m;
                    seconds_next  = load_s;
                    started_next  = 1'b1;
                    running_next  = 1'b1;
                    finished_next = 1'b0;
                end
                hct_pkg::CMD_TOGGLE:
                begin
                    if (!started_reg || finished_reg)
                    begin
                        hours_next   = load_h;
                        minutes_next = load_m;
                        seconds_next = load_s;
                        running_next = 1'b1;
                    end
                    else
                    begin
                        running_next = !running_reg;
                    end
                    started_next  = 1'b1;
                    finished_next = 1'b0;
                end
                hct_pkg::CMD_RESET:
                begin
                    hours_next    = load_h;
                    minutes_next  = load_m;
                    seconds_next  = load_s;
                    started_next  = 1'b0;
                    running_next  = 1'b0;
                    finished_next = 1'b0;
                end
                default: ;
            endcase
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            started_reg   <= 1'b0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            started_reg   <= started_next;
            running_reg   <= running_next;
            finished_reg  <= finished_next;
        end
    end

    // The timer state only changes when a word is written, so it is the result word.
    assign res_ch.valid          = out_valid_reg;
    assign res_ch.remain_hours   = hours_reg;
    assign res_ch.remain_minutes = minutes_reg;
    assign res_ch.remain_secs    = seconds_reg;
    assign res_ch.started_flag   = started_reg;
    assign res_ch.running_flag   = running_reg;
    assign res_ch.finished_flag  = finished_reg;

    a_run_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> started_reg)
        else $error("timer running without having been started");

    a_fin_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        !(finished_reg && running_reg))
        else $error("timer finished and running at once");

    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (minutes_reg <= hct_pkg::MAX_SIXTY) && (seconds_reg <= hct_pkg::MAX_SIXTY))
        else $error("minutes or seconds out of range");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !cfg.timer_valid) |=> ($stable(hours_reg) && $stable(minutes_reg)
            && $stable(seconds_reg) && $stable(running_reg) && $stable(started_reg)))
        else $error("state changed while the timer is not valid");

    a_state_only_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(hours_reg) && $stable(minutes_reg) && $stable(seconds_reg)))
        else $error("time changed without a command word");

endmodule

`default_nettype wire

FILE: rtl/hms_countdown_timer.sv
// Top level of the hours-minutes-seconds countdown timer.
`default_nettype none

// Channel  | Direction | Handshake      | Payload
// ---------+-----------+----------------+---------------------------------------------
// cmd_ch   | in        | valid / ready  | cmd, now_seconds
// res_ch   | out       | valid / ready  | remain_hours, remain_minutes, remain_secs,
//          |           |                | started_flag, running_flag, finished_flag
// cfg_ch   | in        | valid / ready  | index, data (ready is always high)
//
// One result word leaves for every command word; a new command word is taken every
// cycle unless the result side stalls; the throughput is then one word per cycle.
// Each word passes the input register, the load stage (alarm difference and
// the first divide by 60) and the state update stage that ends in the result word.
// Reset clears the written configuration and the timer state, with no clearing pass.
// A stall on the result side backs up through the two internal stages, so up to
// three words can be held in flight while the consumer holds ready low.

module hms_countdown_timer (
    input  wire logic clk,
    input  wire logic rst_n,
    hct_cmd_if.sink   cmd_ch,
    hct_res_if.source res_ch,
    hct_cfg_if.sink   cfg_ch
);

    // Configuration, with the duration seconds already carried into minutes and
    // the alarm time already turned into seconds of the day.
    hct_pkg::hct_cfg_t  cfg;

    // Word between the load stage and the state update stage.
    logic               ld_valid;
    logic               ld_ready;
    hct_pkg::hct_load_t ld;

    hct_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // The reload time is worked out for every command; only start, toggle from
    // an idle or finished timer, and reset actually use it.
    hct_load u_load (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ch   (cmd_ch),
        .cfg      (cfg),
        .ld_valid (ld_valid),
        .ld_ready (ld_ready),
        .ld       (ld)
    );

    // The state update finishes normalization, saturates the hours and applies
    // the command; the updated state is the result word.
    hct_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld_valid (ld_valid),
        .ld_ready (ld_ready),
        .ld       (ld),
        .cfg      (cfg),
        .res_ch   (res_ch)
    );

endmodule

`default_nettype wire
